### design/tah_pkg.sv
// ----------------------------------------------------------------------------
// tah_pkg
// Shared widths and item types of the Heron triangle area pipeline.
// ----------------------------------------------------------------------------
package tah_pkg;

    // Width of each side length
    localparam int SIDE_WIDTH = 12;

    // a+b+c and the signed differences b+c-a etc.
    localparam int SUM_W  = SIDE_WIDTH + 2;
    // Positive factors s2, s3, s4
    localparam int FAC_W  = SIDE_WIDTH + 1;
    // s1*s2 and s3*s4
    localparam int M12_W  = SUM_W + FAC_W;
    localparam int M34_W  = 2 * FAC_W;
    // Split of s3*s4 into two halves for the final product
    localparam int HALF_W = FAC_W;
    localparam int PP_W   = M12_W + HALF_W;
    // Full product P, root width and square root working width
    localparam int P_W    = M12_W + M34_W;
    localparam int ROOT_W = (P_W + 1) / 2;
    localparam int SQ_W   = 2 * ROOT_W;

    // Result field
    localparam int AREA_W = 23;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam int CMP_W  = (SQ_W > AREA_W) ? SQ_W : AREA_W;

    typedef struct packed {
        logic [SIDE_WIDTH-1:0] side_a;
        logic [SIDE_WIDTH-1:0] side_b;
        logic [SIDE_WIDTH-1:0] side_c;
    } t_sides;

    typedef struct packed {
        logic [AREA_W-1:0] area_quarters;
        logic              is_triangle;
    } t_area;

endpackage

### design/tah_side_if.sv
// ----------------------------------------------------------------------------
// tah_side_if
// Valid/ready channel carrying one set of three side lengths.
// ----------------------------------------------------------------------------
interface tah_side_if;
    logic            valid;
    logic            ready;
    tah_pkg::t_sides data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/tah_area_if.sv
// ----------------------------------------------------------------------------
// tah_area_if
// Valid/ready channel carrying one area result and its triangle flag.
// ----------------------------------------------------------------------------
interface tah_area_if;
    logic           valid;
    logic           ready;
    tah_pkg::t_area data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/triangle_area_heron_core.sv
// ----------------------------------------------------------------------------
// triangle_area_heron_core
// Pipelined Heron area: four factors, their product, bitwise square root.
// ----------------------------------------------------------------------------
// Usage:
//   i_sides (sink) takes three unsigned side lengths per item; o_area (source)
//   returns floor(sqrt(s1*s2*s3*s4)), i.e. floor(4 * area), saturated to the
//   23-bit field, plus is_triangle. A degenerate or impossible triangle gives
//   is_triangle = 0 and area 0. Every item gives exactly one result, in order.
//   Stages: one for the factors, one for the two pair products, one for the
//   split partial products, one for their sum, one per root bit
//   (2*SIDE_WIDTH + 3 stages) and one output stage.
//   Throughput: one item per cycle while the skid register is empty; every
//   stage is a register that moves with a common enable.
//   Stall: when the receiver holds o_area.ready low, the waiting result moves
//   into a skid register while the pipeline steps on; while the skid
//   register is full the whole pipeline holds and i_sides.ready is low.
//   Reset (i_rst_n low, synchronous) clears all valid bits, the skid valid
//   bit among them; the data registers keep their contents.
// ----------------------------------------------------------------------------
module triangle_area_heron_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tah_side_if.sink    i_sides,
    tah_area_if.source  o_area
);

    localparam int RW = tah_pkg::ROOT_W;
    localparam int QW = tah_pkg::SQ_W;

    // Pipeline enable: hold everything while the skid register is full
    logic r_skid_v;
    logic en;
    assign en = !r_skid_v;
    assign i_sides.ready = en;

    // ---------------- stage 1: factors and triangle test ----------------
    logic [tah_pkg::SUM_W-1:0] s1, d2, d3, d4;
    logic                      ok;
    logic                      r1_v, r1_ok;
    logic [tah_pkg::SUM_W-1:0] r1_s1;
    logic [tah_pkg::FAC_W-1:0] r1_s2, r1_s3, r1_s4;

    always_comb begin
        s1 = tah_pkg::SUM_W'(i_sides.data.side_a) + tah_pkg::SUM_W'(i_sides.data.side_b)
           + tah_pkg::SUM_W'(i_sides.data.side_c);
        d2 = tah_pkg::SUM_W'(i_sides.data.side_b) + tah_pkg::SUM_W'(i_sides.data.side_c)
           - tah_pkg::SUM_W'(i_sides.data.side_a);
        d3 = tah_pkg::SUM_W'(i_sides.data.side_a) + tah_pkg::SUM_W'(i_sides.data.side_c)
           - tah_pkg::SUM_W'(i_sides.data.side_b);
        d4 = tah_pkg::SUM_W'(i_sides.data.side_a) + tah_pkg::SUM_W'(i_sides.data.side_b)
           - tah_pkg::SUM_W'(i_sides.data.side_c);
        // Strictly positive: sign bit clear and not zero
        ok = !d2[tah_pkg::SUM_W-1] && (d2 != '0)
          && !d3[tah_pkg::SUM_W-1] && (d3 != '0)
          && !d4[tah_pkg::SUM_W-1] && (d4 != '0);
    end

    // Zero the factors of a non-triangle so its product and root are zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ok <= ok;
            r1_s1 <= ok ? s1 : '0;
            r1_s2 <= ok ? d2[tah_pkg::FAC_W-1:0] : '0;
            r1_s3 <= ok ? d3[tah_pkg::FAC_W-1:0] : '0;
            r1_s4 <= ok ? d4[tah_pkg::FAC_W-1:0] : '0;
        end
    end

    // ---------------- stage 2: pair products ----------------
    logic                      r2_v, r2_ok;
    logic [tah_pkg::M12_W-1:0] r2_m12;
    logic [tah_pkg::M34_W-1:0] r2_m34;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ok  <= r1_ok;
            r2_m12 <= tah_pkg::M12_W'(r1_s1) * tah_pkg::M12_W'(r1_s2);
            r2_m34 <= tah_pkg::M34_W'(r1_s3) * tah_pkg::M34_W'(r1_s4);
        end
    end

    // ---------------- stage 3: split partial products ----------------
    logic                     r3_v, r3_ok;
    logic [tah_pkg::PP_W-1:0] r3_plo, r3_phi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok  <= r2_ok;
            r3_plo <= tah_pkg::PP_W'(r2_m12)
                    * tah_pkg::PP_W'(r2_m34[tah_pkg::HALF_W-1:0]);
            r3_phi <= tah_pkg::PP_W'(r2_m12)
                    * tah_pkg::PP_W'(r2_m34[tah_pkg::M34_W-1:tah_pkg::HALF_W]);
        end
    end

    // ---------------- stage 4 onward: product sum, then root bits ----------------
    logic [QW-1:0] r_sq_x    [RW+1];
    logic [QW-1:0] r_sq_root [RW+1];
    logic [RW:0]   r_sq_v;
    logic [RW:0]   r_sq_ok;
    logic [QW-1:0] n_sq_x    [RW+1];
    logic [QW-1:0] n_sq_root [RW+1];

    // One root bit per stage; the trial bit is fixed per stage
    always_comb begin
        logic [QW-1:0] bitv;
        logic [QW-1:0] trial;
        n_sq_x[0]    = QW'(r3_plo) + (QW'(r3_phi) << tah_pkg::HALF_W);
        n_sq_root[0] = '0;
        for (int k = 0; k < RW; k++) begin
            bitv  = QW'(1) << (2 * (RW - 1 - k));
            trial = r_sq_root[k] + bitv;
            if (r_sq_x[k] >= trial) begin
                n_sq_x[k+1]    = r_sq_x[k] - trial;
                n_sq_root[k+1] = (r_sq_root[k] >> 1) + bitv;
            end else begin
                n_sq_x[k+1]    = r_sq_x[k];
                n_sq_root[k+1] = r_sq_root[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_ok <= {r_sq_ok[RW-1:0], r3_ok};
            for (int k = 0; k <= RW; k++) begin
                r_sq_x[k]    <= n_sq_x[k];
                r_sq_root[k] <= n_sq_root[k];
            end
        end
    end

    // ---------------- output stage: saturate ----------------
    logic [tah_pkg::CMP_W-1:0] root_ext;
    logic                      r_out_v;
    tah_pkg::t_area            r_out;
    tah_pkg::t_area            n_out;
    tah_pkg::t_area            r_skid;

    always_comb begin
        root_ext = tah_pkg::CMP_W'(r_sq_root[RW]);
        n_out.is_triangle = r_sq_ok[RW];
        if (root_ext > tah_pkg::CMP_W'(tah_pkg::AREA_MAX)) begin
            n_out.area_quarters = tah_pkg::AREA_MAX;
        end else begin
            n_out.area_quarters = root_ext[tah_pkg::AREA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_sq_v  <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_sides.valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_sq_v  <= {r_sq_v[RW-1:0], r3_v};
            r_out_v <= r_sq_v[RW];
        end
    end

    // ---------------- skid register ----------------
    // Catch the showing item when the pipeline steps under a stalled receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            r_skid_v <= !o_area.ready;
        end else begin
            r_skid_v <= r_out_v && !o_area.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid <= r_out;
        end
    end

    assign o_area.valid = r_skid_v || r_out_v;
    assign o_area.data  = r_skid_v ? r_skid : r_out;

    // ---------------- assertions ----------------
    a_flag_zero_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_area.valid && !o_area.data.is_triangle |-> o_area.data.area_quarters == '0)
        else $error("non-triangle result carries a non-zero area");

    a_factors_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v && r1_ok |-> (r1_s2 != '0) && (r1_s3 != '0) && (r1_s4 != '0))
        else $error("triangle item with a zero factor");

    a_invalid_zero_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[0] && !r_sq_ok[0] |-> r_sq_x[0] == '0)
        else $error("non-triangle item reached the root with a non-zero product");

    a_skid_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_v && r_out_v && !o_area.ready |=> r_skid_v && (r_skid == $past(r_out)))
        else $error("stalled item not held in the skid register");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_v[RW] |-> (r_sq_root[RW] >> RW) == '0)
        else $error("root wider than its bit count");

endmodule

### dv/tah_area_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tah_area_checker
// Watches both channels of the Heron area pipeline, predicts the area and
// triangle flag of every accepted side set, and compares them in order.
// ----------------------------------------------------------------------------
module tah_area_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tah_side_if   sides_mon,
    tah_area_if   area_mon,
    output int    o_fail_count,
    output int    o_pending
);

    tah_pkg::t_area area_queue[$];
    int             mismatches = 0;

    // Bitwise integer root: two bits of the radicand per step, 32 steps.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned trial;
        rem   = x;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            trial = root + probe;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Four times the area from the product of the four Heron factors.
    function automatic tah_pkg::t_area heron_area_of(input tah_pkg::t_sides s);
        tah_pkg::t_area  r;
        longint          la, lb, lc;
        longint          f2, f3, f4;
        longint unsigned prod;
        longint unsigned root;
        la = longint'(s.side_a);
        lb = longint'(s.side_b);
        lc = longint'(s.side_c);
        f2 = lb + lc - la;
        f3 = la + lc - lb;
        f4 = la + lb - lc;
        r  = '0;
        // Flat or impossible triangles read zero with the flag low
        if (f2 > 0 && f3 > 0 && f4 > 0) begin
            prod = longint'(la + lb + lc) * f2 * f3 * f4;
            root = floor_root(prod);
            r.area_quarters = (root > longint'(tah_pkg::AREA_MAX))
                            ? tah_pkg::AREA_MAX : root[tah_pkg::AREA_W-1:0];
            r.is_triangle   = 1'b1;
        end
        return r;
    endfunction

    // Check each result against the oldest prediction, then queue new ones.
    always @(posedge i_clk) begin
        tah_pkg::t_area want;
        tah_pkg::t_area got;
        if (!i_rst_n) begin
            area_queue.delete();
        end else begin
            if (area_mon.valid && area_mon.ready) begin
                got = area_mon.data;
                if (area_queue.size() == 0) begin
                    $error("unexpected result: area_quarters %0d, is_triangle %0d",
                           got.area_quarters, got.is_triangle);
                    mismatches++;
                end else begin
                    want = area_queue.pop_front();
                    if (got.area_quarters !== want.area_quarters) begin
                        $error("area_quarters: expected %0d, actual %0d",
                               want.area_quarters, got.area_quarters);
                        mismatches++;
                    end
                    if (got.is_triangle !== want.is_triangle) begin
                        $error("is_triangle: expected %0d, actual %0d",
                               want.is_triangle, got.is_triangle);
                        mismatches++;
                    end
                end
            end
            if (sides_mon.valid && sides_mon.ready)
                area_queue.push_back(heron_area_of(sides_mon.data));
        end
        o_pending    <= area_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

### dv/tb_triangle_area_heron_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_area_heron_core
// Drives side sets into the Heron area pipeline under random back-pressure:
// a directed set of edge triangles, then random well-formed, flat, small,
// near-equilateral and arbitrary side sets. A checker compares every result.
// ----------------------------------------------------------------------------
module tb_triangle_area_heron_core;

    localparam int LATENCY        = 2 * tah_pkg::SIDE_WIDTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 800;
    localparam int CALM_TAIL      = 120;
    localparam int SIDE_MAX       = (1 << tah_pkg::SIDE_WIDTH) - 1;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;
    bit   idling       = 1'b1;

    tah_side_if sides_if ();
    tah_area_if area_if ();

    triangle_area_heron_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sides (sides_if),
        .o_area  (area_if)
    );

    tah_area_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .sides_mon    (sides_if),
        .area_mon     (area_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side in random bursts while idling is enabled
    initial begin
        int hold;
        hold = 0;
        area_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                area_if.ready <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 19) - 1;
                area_if.ready <= 1'b0;
            end else begin
                area_if.ready <= 1'b1;
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (sides_if.valid && sides_if.ready)
                || (area_if.valid && area_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one side set, after an optional gap, and hold it until taken
    task automatic send_sides(input int a, input int b, input int c);
        tah_pkg::t_sides s;
        int              gap;
        s.side_a = a[tah_pkg::SIDE_WIDTH-1:0];
        s.side_b = b[tah_pkg::SIDE_WIDTH-1:0];
        s.side_c = c[tah_pkg::SIDE_WIDTH-1:0];
        gap = 0;
        if (idling && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            sides_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sides_if.data  <= s;
        sides_if.valid <= 1'b1;
        do @(posedge i_clk); while (!sides_if.ready);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_results();
        sides_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int a, b, c, lo, hi, rot;
        sides_if.valid <= 1'b0;
        sides_if.data  <= '0;
        i_rst_n        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Edge triangles: zero sides, flat and impossible sets, saturation
        send_sides(0, 0, 0);
        send_sides(SIDE_MAX, SIDE_MAX, SIDE_MAX);
        send_sides(1, 1, 1);
        send_sides(SIDE_MAX, SIDE_MAX, 1);
        send_sides(SIDE_MAX, 1, SIDE_MAX);
        send_sides(1, SIDE_MAX, SIDE_MAX);
        send_sides(SIDE_MAX, 0, SIDE_MAX);
        send_sides(0, SIDE_MAX, SIDE_MAX);
        send_sides(SIDE_MAX, SIDE_MAX, 0);
        send_sides(SIDE_MAX, 0, 0);
        send_sides(2, 3, 5);
        send_sides(5, 2, 3);
        send_sides(3, 5, 2);
        send_sides(1, 1, SIDE_MAX);
        send_sides(SIDE_MAX, 2048, 2047);
        send_sides(3, 4, 5);
        send_sides(2201, 2201, 2201);
        send_sides(2202, 2202, 2202);
        send_sides(SIDE_MAX, SIDE_MAX - 1, SIDE_MAX - 2);
        send_sides(2048, 2048, 2048);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch idling off for stretches, and for the whole tail
            if (n % 100 == 0)
                idling = ($urandom_range(0, 3) != 0);
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                idling = 1'b0;
            if (n == RANDOM_ITEMS / 2)
                drain_results();

            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    // Proper triangle: third side strictly between the bounds
                    a  = $urandom_range(1, SIDE_MAX);
                    b  = $urandom_range(1, SIDE_MAX);
                    lo = ((a > b) ? a - b : b - a) + 1;
                    hi = (a + b - 1 > SIDE_MAX) ? SIDE_MAX : a + b - 1;
                    c  = $urandom_range(lo, hi);
                end
                [55:64]: begin
                    // Small sides, many of them flat or zero
                    a = $urandom_range(0, 15);
                    b = $urandom_range(0, 15);
                    c = $urandom_range(0, 15);
                end
                [65:74]: begin
                    // Flat: one side equals the sum of the others
                    a = $urandom_range(0, SIDE_MAX);
                    b = $urandom_range(0, SIDE_MAX - a);
                    c = a + b;
                end
                [75:84]: begin
                    // Near-equilateral long sides, around and above saturation
                    a = $urandom_range(2000, SIDE_MAX);
                    b = a - $urandom_range(0, 60);
                    c = a - $urandom_range(0, 60);
                end
                default: begin
                    a = $urandom_range(0, SIDE_MAX);
                    b = $urandom_range(0, SIDE_MAX);
                    c = $urandom_range(0, SIDE_MAX);
                end
            endcase

            // Rotate so that each port sees every role
            rot = $urandom_range(0, 2);
            case (rot)
                0:       send_sides(a, b, c);
                1:       send_sides(b, c, a);
                default: send_sides(c, a, b);
            endcase
        end

        drain_results();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
